// ===== rtl/core/cst_pkg.sv =====
// shared types and constants for the comment-stripping tokenizer
`timescale 1ns / 1ps

package cst_pkg;

   localparam int KIND_BITS = 3;
   localparam int LINE_OUT_BITS = 24;
   localparam int COL_OUT_BITS = 16;
   localparam int WORD_BITS = 16;
   localparam int ERR_BITS = 2;
   localparam int CHAR_BITS = 8;

   localparam logic [KIND_BITS-1:0] KIND_WORD = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_COMMA = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_SEMI = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_EOF = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_ERROR = 3'd7;

   localparam logic [ERR_BITS-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_OPEN_BLOCK = 2'd2;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END = 1'b1;

   localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_STAR = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_VTAB = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CH_FORMFEED = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_RETURN = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_SEMI = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_LBRACK = 8'h5B;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_SLASH  = 3'd2,
      MODE_LINEC  = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_BSTAR  = 3'd5,
      MODE_HALT   = 3'd6
   } mode_type;

   typedef struct packed {
      logic                 cmd;
      logic [CHAR_BITS-1:0] char_code;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     token_kind;
      logic [LINE_OUT_BITS-1:0] start_line;
      logic [COL_OUT_BITS-1:0]  start_col;
      logic [WORD_BITS-1:0]     word_length;
      logic [ERR_BITS-1:0]      error_code;
      logic [CHAR_BITS-1:0]     bad_char;
      logic                     last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

// ===== rtl/core/cst_chan_if.sv =====
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps

interface cst_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

// ===== rtl/core/cst_scan.sv =====
// scanner state and per-byte token decode
`timescale 1ns / 1ps

module cst_scan #(
   parameter int LINE_BITS = 24,
   parameter int COL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  cst_pkg::req_payload_type item,
   output cst_pkg::push_type        push,
   output cst_pkg::rsp_payload_type res0,
   output cst_pkg::rsp_payload_type res1
);

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [COL_BITS-1:0] COL_ONE = COL_BITS'(1);
   localparam logic [cst_pkg::WORD_BITS-1:0] LEN_ONE = cst_pkg::WORD_BITS'(1);

   cst_pkg::mode_type mode_ff, mode_in;
   logic [LINE_BITS-1:0] line_ff, line_in, mark_line_ff, mark_line_in, adv_line;
   logic [COL_BITS-1:0] col_ff, col_in, mark_col_ff, mark_col_in, adv_col;
   logic [cst_pkg::WORD_BITS-1:0] wlen_ff, wlen_in;

   logic [cst_pkg::CHAR_BITS-1:0] c;
   logic is_blank, is_head, is_tail, is_punct, word_end, norm_emit;
   logic [cst_pkg::KIND_BITS-1:0] punct_kind;
   cst_pkg::rsp_payload_type word_res, eof_res, norm_res, slash_err, block_err;
   cst_pkg::rsp_payload_type r0, r1;
   logic p0, p1;

   assign c = item.char_code;

   assign is_blank = (c == cst_pkg::CH_SPACE) || (c == cst_pkg::CH_TAB)
                  || (c == cst_pkg::CH_NEWLINE) || (c == cst_pkg::CH_RETURN)
                  || (c == cst_pkg::CH_FORMFEED) || (c == cst_pkg::CH_VTAB);
   assign is_head = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                 || (c == cst_pkg::CH_UNDERSCORE);
   assign is_tail = is_head || (c >= 8'h30 && c <= 8'h39) || (c == cst_pkg::CH_DOLLAR);

   always_comb begin
      is_punct = 1'b1;
      case (c)
         cst_pkg::CH_LPAREN: punct_kind = cst_pkg::KIND_LPAREN;
         cst_pkg::CH_RPAREN: punct_kind = cst_pkg::KIND_RPAREN;
         cst_pkg::CH_COMMA:  punct_kind = cst_pkg::KIND_COMMA;
         cst_pkg::CH_SEMI:   punct_kind = cst_pkg::KIND_SEMI;
         cst_pkg::CH_LBRACK: punct_kind = cst_pkg::KIND_LBRACK;
         default: begin
            punct_kind = cst_pkg::KIND_ERROR;
            is_punct = 1'b0;
         end
      endcase
   end

   // position after this byte, saturating
   always_comb begin
      adv_line = line_ff;
      adv_col = col_ff;
      if (c == cst_pkg::CH_NEWLINE) begin
         if (line_ff != {LINE_BITS{1'b1}}) adv_line = line_ff + LINE_ONE;
         adv_col = COL_ONE;
      end else if (col_ff != {COL_BITS{1'b1}}) begin
         adv_col = col_ff + COL_ONE;
      end
   end

   assign word_end = (mode_ff == cst_pkg::MODE_WORD) && !is_tail;
   assign norm_emit = !is_blank && !is_head && (c != cst_pkg::CH_SLASH);

   always_comb begin
      word_res = '0;
      word_res.token_kind = cst_pkg::KIND_WORD;
      word_res.start_line = cst_pkg::LINE_OUT_BITS'(mark_line_ff);
      word_res.start_col = cst_pkg::COL_OUT_BITS'(mark_col_ff);
      word_res.word_length = wlen_ff;

      eof_res = '0;
      eof_res.token_kind = cst_pkg::KIND_EOF;
      eof_res.start_line = cst_pkg::LINE_OUT_BITS'(line_ff);
      eof_res.start_col = cst_pkg::COL_OUT_BITS'(col_ff);

      norm_res = '0;
      norm_res.token_kind = punct_kind;
      norm_res.start_line = cst_pkg::LINE_OUT_BITS'(line_ff);
      norm_res.start_col = cst_pkg::COL_OUT_BITS'(col_ff);
      norm_res.error_code = is_punct ? cst_pkg::ERR_NONE : cst_pkg::ERR_UNEXPECTED;
      norm_res.bad_char = is_punct ? '0 : c;

      slash_err = '0;
      slash_err.token_kind = cst_pkg::KIND_ERROR;
      slash_err.start_line = cst_pkg::LINE_OUT_BITS'(mark_line_ff);
      slash_err.start_col = cst_pkg::COL_OUT_BITS'(mark_col_ff);
      slash_err.error_code = cst_pkg::ERR_UNEXPECTED;
      slash_err.bad_char = cst_pkg::CH_SLASH;

      block_err = '0;
      block_err.token_kind = cst_pkg::KIND_ERROR;
      block_err.start_line = cst_pkg::LINE_OUT_BITS'(mark_line_ff);
      block_err.start_col = cst_pkg::COL_OUT_BITS'(mark_col_ff);
      block_err.error_code = cst_pkg::ERR_OPEN_BLOCK;
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      line_in = line_ff;
      col_in = col_ff;
      mark_line_in = mark_line_ff;
      mark_col_in = mark_col_ff;
      wlen_in = wlen_ff;
      if (item.cmd == cst_pkg::CMD_END) begin
         mode_in = cst_pkg::MODE_NORMAL;
         line_in = LINE_ONE;
         col_in = COL_ONE;
         mark_line_in = LINE_ONE;
         mark_col_in = COL_ONE;
         wlen_in = '0;
      end else begin
         unique case (mode_ff)
            cst_pkg::MODE_WORD: begin
               if (is_tail) begin
                  if (wlen_ff != {cst_pkg::WORD_BITS{1'b1}}) wlen_in = wlen_ff + LEN_ONE;
                  line_in = adv_line;
                  col_in = adv_col;
               end
            end
            cst_pkg::MODE_SLASH: begin
               if (c == cst_pkg::CH_SLASH) begin
                  mode_in = cst_pkg::MODE_LINEC;
                  line_in = adv_line;
                  col_in = adv_col;
               end else if (c == cst_pkg::CH_STAR) begin
                  mode_in = cst_pkg::MODE_BLOCK;
                  line_in = adv_line;
                  col_in = adv_col;
               end else begin
                  mode_in = cst_pkg::MODE_HALT;
               end
            end
            cst_pkg::MODE_LINEC: begin
               if (c == cst_pkg::CH_NEWLINE) mode_in = cst_pkg::MODE_NORMAL;
               line_in = adv_line;
               col_in = adv_col;
            end
            cst_pkg::MODE_BLOCK: begin
               if (c == cst_pkg::CH_STAR) mode_in = cst_pkg::MODE_BSTAR;
               line_in = adv_line;
               col_in = adv_col;
            end
            cst_pkg::MODE_BSTAR: begin
               if (c == cst_pkg::CH_SLASH) mode_in = cst_pkg::MODE_NORMAL;
               else if (c != cst_pkg::CH_STAR) mode_in = cst_pkg::MODE_BLOCK;
               line_in = adv_line;
               col_in = adv_col;
            end
            cst_pkg::MODE_HALT: begin
            end
            default: begin
            end
         endcase
         // normal scan, also for the byte that ends a word
         if (mode_ff == cst_pkg::MODE_NORMAL || word_end) begin
            wlen_in = '0;
            mode_in = cst_pkg::MODE_NORMAL;
            if (is_head || c == cst_pkg::CH_SLASH) begin
               mark_line_in = line_ff;
               mark_col_in = col_ff;
               mode_in = is_head ? cst_pkg::MODE_WORD : cst_pkg::MODE_SLASH;
               if (is_head) wlen_in = LEN_ONE;
            end
            if (is_blank || is_head || is_punct || c == cst_pkg::CH_SLASH) begin
               line_in = adv_line;
               col_in = adv_col;
            end else begin
               mode_in = cst_pkg::MODE_HALT;
            end
         end
      end
   end

   // result beats
   always_comb begin
      r0 = norm_res;
      r1 = norm_res;
      p0 = 1'b0;
      p1 = 1'b0;
      if (item.cmd == cst_pkg::CMD_END) begin
         unique case (mode_ff) inside
            cst_pkg::MODE_WORD: begin
               r0 = word_res;
               r1 = eof_res;
               p0 = 1'b1;
               p1 = 1'b1;
            end
            cst_pkg::MODE_SLASH: begin
               r0 = slash_err;
               p0 = 1'b1;
            end
            cst_pkg::MODE_BLOCK, cst_pkg::MODE_BSTAR: begin
               r0 = block_err;
               p0 = 1'b1;
            end
            cst_pkg::MODE_HALT: begin
            end
            default: begin
               r0 = eof_res;
               p0 = 1'b1;
            end
         endcase
      end else begin
         unique case (mode_ff) inside
            cst_pkg::MODE_WORD: begin
               if (word_end) begin
                  r0 = word_res;
                  p0 = 1'b1;
                  p1 = norm_emit;
               end
            end
            cst_pkg::MODE_SLASH: begin
               if (c != cst_pkg::CH_SLASH && c != cst_pkg::CH_STAR) begin
                  r0 = slash_err;
                  p0 = 1'b1;
               end
            end
            cst_pkg::MODE_LINEC, cst_pkg::MODE_BLOCK, cst_pkg::MODE_BSTAR,
            cst_pkg::MODE_HALT: begin
            end
            default: begin
               p0 = norm_emit;
            end
         endcase
      end
      r0.last_of_run = !p1;
      r1.last_of_run = 1'b1;
   end

   assign res0 = r0;
   assign res1 = r1;
   assign push.first = step && p0;
   assign push.second = step && p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cst_pkg::MODE_NORMAL;
         line_ff <= LINE_ONE;
         col_ff <= COL_ONE;
         mark_line_ff <= LINE_ONE;
         mark_col_ff <= COL_ONE;
         wlen_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff <= col_in;
         mark_line_ff <= mark_line_in;
         mark_col_ff <= mark_col_in;
         wlen_ff <= wlen_in;
      end
   end

endmodule

// ===== rtl/core/cst_rsp_fifo.sv =====
// four-entry result queue taking up to two beats per cycle
`timescale 1ns / 1ps

module cst_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  cst_pkg::push_type        push,
   input  cst_pkg::rsp_payload_type res0,
   input  cst_pkg::rsp_payload_type res1,
   output logic                     room,
   cst_chan_if.source               rsp_chan
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   cst_pkg::rsp_payload_type mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign wr_next = wr_ptr_ff + PTR_BITS'(1);
   // two free slots needed before the scanner may take a byte
   assign room = (count_ff <= CNT_BITS'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.first) + PTR_BITS'(push.second);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push.first) + CNT_BITS'(push.second)
               - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) mem_ff[wr_ptr_ff] <= res0;
      if (push.second) mem_ff[wr_next] <= res1;
   end

   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.payload = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/comment_stripping_tokenizer_top.sv =====
// top level of the comment-stripping tokenizer
`timescale 1ns / 1ps

// Tokenizer for C-style source text: one byte (or end-of-text marker) per req beat, tokens
// out on rsp. A byte is taken every cycle as long as the four-entry result queue has two free
// slots; the scanner itself decodes each byte combinationally behind the input register. Most
// bytes make zero or one result beat; a byte that ends a word and also forms a token or error
// makes two, as does an end-of-text marker that ends a word, and the rsp port drains one beat
// per cycle while rsp is ready. A req beat passes through the input register and the result
// queue before its first rsp beat. After an error the stream is halted until the next
// end-of-text marker, which always rearms the scanner to line 1, column 1.
module comment_stripping_tokenizer_top #(
   parameter int LINE_BITS = 24,
   parameter int COL_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   cst_chan_if.sink   req_chan,
   cst_chan_if.source rsp_chan
);

   logic in_valid_ff, in_valid_in;
   cst_pkg::req_payload_type in_data_ff;
   logic room, step, take;
   cst_pkg::push_type push;
   cst_pkg::rsp_payload_type res0, res1;

   assign step = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || room;
   assign take = req_chan.valid && req_chan.ready;
   assign in_valid_in = take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) in_data_ff <= req_chan.payload;
   end

   cst_scan #(
      .LINE_BITS(LINE_BITS),
      .COL_BITS(COL_BITS)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .step(step),
      .item(in_data_ff),
      .push(push),
      .res0(res0),
      .res1(res1)
   );

   cst_rsp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .res0(res0),
      .res1(res1),
      .room(room),
      .rsp_chan(rsp_chan)
   );

endmodule

// ===== rtl/core/cst_checker.sv =====
// port-level checks for the tokenizer and their bind
`timescale 1ns / 1ps

module cst_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input cst_pkg::rsp_payload_type rsp_payload
);

   // a pending result beat is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // error kind and error code go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_payload.token_kind == cst_pkg::KIND_ERROR) ==
          (rsp_payload.error_code != cst_pkg::ERR_NONE)))
      else $error("error code does not match token kind");

   // only a word can be followed by another beat from the same byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_of_run |->
         rsp_payload.token_kind == cst_pkg::KIND_WORD)
      else $error("non-word beat not last of its run");

   // words have a length, everything else has none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_payload.token_kind == cst_pkg::KIND_WORD) ==
          (rsp_payload.word_length != '0)))
      else $error("word length inconsistent with token kind");

   // an empty result queue never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with nothing queued");

endmodule

bind comment_stripping_tokenizer_top cst_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
